// File: src/terminal_line_editor_macros.svh
// Assertion macros used by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLE_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLE_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tle_pkg.sv
// Types and constants of the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int KIND_W = 3;
   localparam int OUT_W  = 6;

   // Key bytes
   localparam logic [BYTE_W-1:0] KEY_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] KEY_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] KEY_ENTER = 8'h0D;
   localparam logic [BYTE_W-1:0] KEY_DEL   = 8'h7F;

   // Third byte of an escape sequence
   localparam logic [BYTE_W-1:0] ESC_LEFT  = 8'h44;
   localparam logic [BYTE_W-1:0] ESC_RIGHT = 8'h43;
   localparam logic [BYTE_W-1:0] ESC_HOME  = 8'h31;
   localparam logic [BYTE_W-1:0] ESC_END   = 8'h34;

   // Echo kinds
   typedef enum logic [KIND_W-1:0] {
      K_NONE     = 3'd0,
      K_LEFT     = 3'd1,
      K_RIGHT    = 3'd2,
      K_ERASE_L  = 3'd3,
      K_ERASE_AT = 3'd4,
      K_INSERT   = 3'd5,
      K_LBYTE    = 3'd6,
      K_DONE     = 3'd7
   } echo_kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_REMOVE,
      ST_DRAIN,
      ST_REPLY
   } state_type;

endpackage

// File: src/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/terminal_line_editor.sv
// Terminal line editor: key events in, echo items out, line kept in a RAM.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_key_byte, req_escape_code
//   rsp      out        rsp_valid / rsp_stall   rsp_echo_kind .. rsp_last
//
// Cursor moves and dropped keys go straight to the reply. Insert and delete move one
// character per cycle through the line RAM, reading one entry while writing the last.
// Enter streams one line byte per cycle while rsp is not stalled, then the done item.
// Reset clears cursor, length and control; the line RAM needs no clearing.
// A stalled rsp holds the sequencer only where it has an item to hand over.
`timescale 1ns / 1ps

`include "terminal_line_editor_macros.svh"

module terminal_line_editor #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tle_pkg::BYTE_W-1:0]  req_key_byte,
   input  logic [tle_pkg::BYTE_W-1:0]  req_escape_code,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tle_pkg::KIND_W-1:0]  rsp_echo_kind,
   output logic [tle_pkg::OUT_W-1:0]   rsp_echo_count,
   output logic [tle_pkg::BYTE_W-1:0]  rsp_echo_byte,
   output logic [tle_pkg::OUT_W-1:0]   rsp_cursor_pos,
   output logic [tle_pkg::OUT_W-1:0]   rsp_line_length,
   output logic                        rsp_last
);

   import tle_pkg::*;

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // Control state
   state_type state_ff, state_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] length_ff, length_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Sequencer working registers
   logic [CW-1:0] mov_ff, mov_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [BYTE_W-1:0] key_ff, key_in;
   echo_kind_type kind_ff, kind_in;
   logic [CW-1:0] count_ff, count_in;

   // Output registers
   echo_kind_type     out_kind_ff, out_kind_in;
   logic [OUT_W-1:0]  out_count_ff, out_count_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [OUT_W-1:0]  out_cursor_ff, out_cursor_in;
   logic [OUT_W-1:0]  out_length_ff, out_length_in;
   logic              out_last_ff, out_last_in;

   // RAM port
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   logic out_free;
   logic accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   tle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, datapath control and output loading
   always_comb begin
      logic load;
      logic issue;
      load          = 1'b0;
      issue         = 1'b0;
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      length_in     = length_ff;
      pend_in       = pend_ff;
      mov_in        = mov_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      wr_addr_in    = wr_addr_ff;
      key_in        = key_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      out_kind_in   = out_kind_ff;
      out_count_in  = out_count_ff;
      out_byte_in   = out_byte_ff;
      out_cursor_in = out_cursor_ff;
      out_length_in = out_length_ff;
      out_last_in   = out_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = mov_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_key_byte;
               kind_in  = K_NONE;
               count_in = ONE_C;
               state_in = ST_REPLY;
               priority if (req_key_byte == KEY_ESC) begin
                  priority if (req_escape_code == ESC_LEFT && cursor_ff != '0) begin
                     cursor_in = cursor_ff - ONE_C;
                     kind_in   = K_LEFT;
                  end else if (req_escape_code == ESC_RIGHT && cursor_ff < length_ff) begin
                     cursor_in = cursor_ff + ONE_C;
                     kind_in   = K_RIGHT;
                  end else if (req_escape_code == ESC_HOME && cursor_ff != '0) begin
                     count_in  = cursor_ff;
                     cursor_in = '0;
                     kind_in   = K_LEFT;
                  end else if (req_escape_code == ESC_END && cursor_ff < length_ff) begin
                     count_in  = length_ff - cursor_ff;
                     cursor_in = length_ff;
                     kind_in   = K_RIGHT;
                  end else begin
                     kind_in = K_NONE;
                  end
               end else if (req_key_byte == KEY_BS) begin
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - ONE_C;
                     length_in = length_ff - ONE_C;
                     mov_in    = cursor_ff - ONE_C;
                     end_in    = length_ff;
                     kind_in   = K_ERASE_L;
                     state_in  = ST_REMOVE;
                  end
               end else if (req_key_byte == KEY_ENTER) begin
                  cursor_in = '0;
                  length_in = '0;
                  mov_in    = '0;
                  end_in    = length_ff;
                  state_in  = ST_DRAIN;
               end else if (req_key_byte == KEY_DEL) begin
                  if (cursor_ff < length_ff) begin
                     length_in = length_ff - ONE_C;
                     mov_in    = cursor_ff;
                     end_in    = length_ff;
                     kind_in   = K_ERASE_AT;
                     state_in  = ST_REMOVE;
                  end
               end else begin
                  if (length_ff < DEPTH_C) begin
                     pos_in    = cursor_ff;
                     mov_in    = length_ff;
                     cursor_in = cursor_ff + ONE_C;
                     length_in = length_ff + ONE_C;
                     kind_in   = K_INSERT;
                     state_in  = ST_INSERT;
                  end
               end
            end
         end

         // Open a gap: move entries up one, highest first, then write the key
         ST_INSERT: begin
            ram_wr_en = pend_ff;
            if (mov_ff > pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(mov_ff - ONE_C);
               wr_addr_in  = mov_ff[AW-1:0];
               mov_in      = mov_ff - ONE_C;
               pend_in     = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[AW-1:0];
               ram_wr_data = key_ff;
               state_in    = ST_REPLY;
            end
         end

         // Close a gap: move entries down one, lowest first
         ST_REMOVE: begin
            ram_wr_en = pend_ff;
            if ((mov_ff + ONE_C) < end_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(mov_ff + ONE_C);
               wr_addr_in  = mov_ff[AW-1:0];
               mov_in      = mov_ff + ONE_C;
               pend_in     = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = ST_REPLY;
            end
         end

         // Stream the line one byte per cycle while rsp is not stalled, read one ahead
         ST_DRAIN: begin
            issue = (!pend_ff || out_free) && (mov_ff < end_ff);
            if (pend_ff && out_free) begin
               load          = 1'b1;
               out_kind_in   = K_LBYTE;
               out_byte_in   = ram_rd_data;
               out_last_in   = 1'b0;
            end else if (!pend_ff && (mov_ff == end_ff) && out_free) begin
               load          = 1'b1;
               out_kind_in   = K_DONE;
               out_byte_in   = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
            if (load) begin
               out_count_in  = OUT_W'(ONE_C);
               out_cursor_in = '0;
               out_length_in = '0;
            end
            ram_rd_en = issue;
            if (issue) begin
               mov_in = mov_ff + ONE_C;
            end
            pend_in = issue || (pend_ff && !out_free);
         end

         // Single result once the output register is free
         ST_REPLY: begin
            if (out_free) begin
               load          = 1'b1;
               out_kind_in   = kind_ff;
               out_count_in  = OUT_W'(count_ff);
               out_byte_in   = (kind_ff == K_INSERT) ? key_ff : '0;
               out_cursor_in = OUT_W'(cursor_ff);
               out_length_in = OUT_W'(length_ff);
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      mov_ff        <= mov_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      wr_addr_ff    <= wr_addr_in;
      key_ff        <= key_in;
      kind_ff       <= kind_in;
      count_ff      <= count_in;
      out_kind_ff   <= out_kind_in;
      out_count_ff  <= out_count_in;
      out_byte_ff   <= out_byte_in;
      out_cursor_ff <= out_cursor_in;
      out_length_ff <= out_length_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_kind   = out_kind_ff;
   assign rsp_echo_count  = out_count_ff;
   assign rsp_echo_byte   = out_byte_ff;
   assign rsp_cursor_pos  = out_cursor_ff;
   assign rsp_line_length = out_length_ff;
   assign rsp_last        = out_last_ff;

   // Checks
   `TLE_CHECK(a_cursor_in_line, clock, reset, 1'b1, cursor_ff <= length_ff, "cursor past end of line")
   `TLE_CHECK(a_length_in_depth, clock, reset, 1'b1, length_ff <= DEPTH_C, "line longer than depth")
   `TLE_CHECK(a_no_pend_idle, clock, reset, state_ff == ST_IDLE || state_ff == ST_REPLY, !pend_ff, "RAM data left pending outside a pass")
   `TLE_CHECK(a_line_byte_cleared, clock, reset, rsp_valid_ff && out_kind_ff == K_LBYTE, out_cursor_ff == '0 && out_length_ff == '0 && !out_last_ff, "line byte with live line state")
   `TLE_CHECK_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE, "item accepted but sequencer idle")

endmodule

// File: tb/terminal_line_editor_checker.sv
// Checker for the terminal line editor: predicts echo items and compares them.
`timescale 1ns / 1ps

module terminal_line_editor_checker #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [tle_pkg::BYTE_W-1:0]  req_key_byte,
   input  logic [tle_pkg::BYTE_W-1:0]  req_escape_code,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [tle_pkg::KIND_W-1:0]  rsp_echo_kind,
   input  logic [tle_pkg::OUT_W-1:0]   rsp_echo_count,
   input  logic [tle_pkg::BYTE_W-1:0]  rsp_echo_byte,
   input  logic [tle_pkg::OUT_W-1:0]   rsp_cursor_pos,
   input  logic [tle_pkg::OUT_W-1:0]   rsp_line_length,
   input  logic                        rsp_last,
   output int                          echoes_pending,
   output int                          error_count
);
   import tle_pkg::*;

   typedef struct packed {
      echo_kind_type     kind;
      logic [OUT_W-1:0]  count;
      logic [BYTE_W-1:0] ch;
      logic [OUT_W-1:0]  cursor;
      logic [OUT_W-1:0]  length;
      logic              last;
   } echo_type;

   // Shadow copy of the editor state
   logic [BYTE_W-1:0] line_chars [LINE_DEPTH];
   int                cur;
   int                len;
   int                errors;

   echo_type echo_expected [$];

   // Echo item built from the state after the step
   function automatic echo_type make_echo(echo_kind_type kind, int count,
                                          logic [BYTE_W-1:0] ch, logic last);
      echo_type e;
      e.kind   = kind;
      e.count  = OUT_W'(count);
      e.ch     = ch;
      e.cursor = OUT_W'(cur);
      e.length = OUT_W'(len);
      e.last   = last;
      return e;
   endfunction

   // Close the gap left by the character at position p
   task automatic close_gap(int p);
      for (int i = p; i + 1 < len; i++) line_chars[i] = line_chars[i + 1];
      len--;
   endtask

   // Apply one key event to the shadow state and queue its echoes
   task automatic predict_key_echo(logic [BYTE_W-1:0] key, logic [BYTE_W-1:0] esc);
      echo_kind_type kind;
      int            count;
      logic [BYTE_W-1:0] ch;
      int            n;
      kind  = K_NONE;
      count = 1;
      ch    = '0;
      if (key == KEY_ESC) begin
         if (esc == ESC_LEFT && cur > 0) begin
            cur--;
            kind = K_LEFT;
         end else if (esc == ESC_RIGHT && cur < len) begin
            cur++;
            kind = K_RIGHT;
         end else if (esc == ESC_HOME && cur > 0) begin
            count = cur;
            cur   = 0;
            kind  = K_LEFT;
         end else if (esc == ESC_END && cur < len) begin
            count = len - cur;
            cur   = len;
            kind  = K_RIGHT;
         end
      end else if (key == KEY_BS) begin
         if (cur > 0 && len > 0) begin
            cur--;
            close_gap(cur);
            kind = K_ERASE_L;
         end
      end else if (key == KEY_ENTER) begin
         // whole line streams out, reported with the cleared state
         n   = len;
         cur = 0;
         len = 0;
         for (int i = 0; i < n; i++)
            echo_expected.push_back(make_echo(K_LBYTE, 1, line_chars[i], 1'b0));
         echo_expected.push_back(make_echo(K_DONE, 1, '0, 1'b1));
         return;
      end else if (key == KEY_DEL) begin
         if (len > 0 && cur < len) begin
            close_gap(cur);
            kind = K_ERASE_AT;
         end
      end else begin
         // insertion, dropped on a full line
         if (len < LINE_DEPTH && cur <= len) begin
            for (int i = len; i > cur; i--) line_chars[i] = line_chars[i - 1];
            line_chars[cur] = key;
            cur++;
            len++;
            kind = K_INSERT;
            ch   = key;
         end
      end
      echo_expected.push_back(make_echo(kind, count, ch, 1'b1));
   endtask

   // Result side first: a result never comes from the item accepted at the same edge
   always @(posedge clock) begin
      echo_type want;
      echo_type got;
      if (reset) begin
         cur = 0;
         len = 0;
         echo_expected.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind   = echo_kind_type'(rsp_echo_kind);
            got.count  = rsp_echo_count;
            got.ch     = rsp_echo_byte;
            got.cursor = rsp_cursor_pos;
            got.length = rsp_line_length;
            got.last   = rsp_last;
            if (echo_expected.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected echo kind=%0d count=%0d byte=%02h",
                           $realtime, got.kind, got.count, got.ch,
                           "   cur=%0d len=%0d last=%0b", got.cursor, got.length,
                           got.last);
            end else begin
               want = echo_expected.pop_front();
               if (got.kind !== want.kind || got.count !== want.count || got.ch !== want.ch ||
                   got.cursor !== want.cursor || got.length !== want.length ||
                   got.last !== want.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: echo mismatch", $realtime);
                     $display("   expected kind=%0d count=%0d byte=%02h cur=%0d len=%0d last=%0b",
                              want.kind, want.count, want.ch, want.cursor, want.length,
                              want.last);
                     $display("   actual   kind=%0d count=%0d byte=%02h cur=%0d len=%0d last=%0b",
                              got.kind, got.count, got.ch, got.cursor, got.length, got.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) predict_key_echo(req_key_byte, req_escape_code);
      end
      echoes_pending <= echo_expected.size();
      error_count    <= errors;
   end

endmodule

// File: tb/terminal_line_editor_tb.sv
// Top of the terminal line editor testbench: clock, reset, key stimulus and verdict.
`timescale 1ns / 1ps

module terminal_line_editor_tb;
   import tle_pkg::*;

   localparam int LINE_DEPTH     = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_KEYS    = 40;

   // Escape code that matches no cursor command (arrow up)
   localparam logic [BYTE_W-1:0] ESC_UP   = 8'h41;
   localparam logic [BYTE_W-1:0] ESC_DOWN = 8'h42;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_key_byte    = '0;
   logic [BYTE_W-1:0] req_escape_code = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [KIND_W-1:0] rsp_echo_kind;
   logic [OUT_W-1:0]  rsp_echo_count;
   logic [BYTE_W-1:0] rsp_echo_byte;
   logic [OUT_W-1:0]  rsp_cursor_pos;
   logic [OUT_W-1:0]  rsp_line_length;
   logic              rsp_last;

   int echoes_pending;
   int error_count;

   int   keys_sent    = 0;
   int   burst_left   = 0;
   int   idle_cycles  = 0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;

   always #4 clock = ~clock;

   terminal_line_editor #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_byte    (req_key_byte),
      .req_escape_code (req_escape_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_kind   (rsp_echo_kind),
      .rsp_echo_count  (rsp_echo_count),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   terminal_line_editor_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_byte    (req_key_byte),
      .req_escape_code (req_escape_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_kind   (rsp_echo_kind),
      .rsp_echo_count  (rsp_echo_count),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .echoes_pending  (echoes_pending),
      .error_count     (error_count)
   );

   // Watchdog: cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: random stall patterns plus one long hold-off on request
   initial begin
      int mode;
      int run;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(5, 60);
         repeat (run) begin
            @(posedge clock);
            if (hold_request && !hold_done) begin
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(posedge clock);
               hold_done = 1'b1;
               rsp_stall <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ($urandom_range(0, 7) == 0);
               endcase
            end
         end
      end
   end

   // Offer one key item and wait for its acceptance; called at a rising edge
   task automatic send_key(logic [BYTE_W-1:0] key, logic [BYTE_W-1:0] esc);
      req_valid       <= 1'b1;
      req_key_byte    <= key;
      req_escape_code <= esc;
      do @(posedge clock); while (req_stall);
      keys_sent++;
   endtask

   // Send in bursts, with idle gaps between them
   task automatic offer(logic [BYTE_W-1:0] key, logic [BYTE_W-1:0] esc);
      send_key(key, esc);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Pause the sender until every expected echo has arrived
   task automatic wait_all_echoes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (echoes_pending != 0) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] rand_char();
      logic [BYTE_W-1:0] c;
      do c = BYTE_W'($urandom_range(0, 255));
      while (c == KEY_ESC || c == KEY_BS || c == KEY_ENTER || c == KEY_DEL);
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_esc();
      case ($urandom_range(0, 5))
         0: return ESC_LEFT;
         1: return ESC_RIGHT;
         2: return ESC_HOME;
         3: return ESC_END;
         4: return ($urandom_range(0, 1) != 0) ? ESC_UP : ESC_DOWN;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Cursor moves and erasures on the current line
   task automatic edit_keys(int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: offer(KEY_BS, rand_byte());
            1: offer(KEY_DEL, rand_byte());
            default: offer(KEY_ESC, rand_esc());
         endcase
      end
   endtask

   initial begin
      int random_start;
      int kind_pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: nothing-to-do cases on an empty line
      offer(KEY_ENTER, rand_byte());
      offer(KEY_ESC, ESC_LEFT);
      offer(KEY_ESC, ESC_RIGHT);
      offer(KEY_ESC, ESC_HOME);
      offer(KEY_ESC, ESC_END);
      offer(KEY_BS, rand_byte());
      offer(KEY_DEL, rand_byte());
      offer(KEY_ESC, ESC_UP);
      // extreme characters, then moves, erasures and insert in the middle
      offer(8'h00, 8'hFF);
      offer(8'hFF, 8'h00);
      offer(8'h41, rand_byte());
      offer(8'h80, rand_byte());
      offer(KEY_ESC, ESC_HOME);
      offer(KEY_DEL, rand_byte());
      offer(KEY_ESC, ESC_RIGHT);
      offer(8'h1C, rand_byte());
      offer(KEY_ESC, ESC_END);
      offer(KEY_ESC, ESC_LEFT);
      offer(KEY_BS, rand_byte());
      offer(KEY_ESC, ESC_LEFT);
      offer(KEY_ESC, ESC_DOWN);
      offer(KEY_ENTER, rand_byte());
      wait_all_echoes();

      // Fill the line past full, then drain the longest echo stream
      repeat (LINE_DEPTH + 2) offer(rand_char(), rand_byte());
      offer(KEY_ESC, ESC_HOME);
      offer(KEY_ESC, ESC_END);
      offer(KEY_ENTER, rand_byte());

      // Random sessions: typing, editing, enter, noise
      random_start = keys_sent;
      while (keys_sent < random_start + RANDOM_KEYS) begin
         if (!hold_request && keys_sent >= random_start + RANDOM_KEYS / 2) begin
            // long receiver hold-off while keys keep coming
            hold_request = 1'b1;
            repeat (12) send_key(rand_char(), rand_byte());
            edit_keys(4);
            send_key(KEY_ENTER, rand_byte());
         end
         kind_pick = $urandom_range(0, 9);
         case (kind_pick)
            0, 1, 2, 3: repeat ($urandom_range(1, 8)) offer(rand_char(), rand_byte());
            4, 5: edit_keys($urandom_range(1, 6));
            6: offer(KEY_ENTER, rand_byte());
            7: repeat ($urandom_range(1, 4)) offer(rand_byte(), rand_byte());
            8: begin
               wait_all_echoes();
               offer(KEY_ENTER, rand_byte());
            end
            default: begin
               repeat ($urandom_range(2, 6)) offer(rand_char(), rand_byte());
               edit_keys($urandom_range(1, 3));
               offer(KEY_ENTER, rand_byte());
            end
         endcase
      end
      offer(KEY_ENTER, rand_byte());

      // Drain and let the block settle
      wait_all_echoes();
      repeat (100) @(posedge clock);
      if (error_count == 0 && echoes_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/tle_pkg.sv
src/tle_ram.sv
src/terminal_line_editor.sv
tb/terminal_line_editor_checker.sv
tb/terminal_line_editor_tb.sv
